[hw/rtl/pts_pkg.sv]
`default_nettype none
package pts_pkg;

  // fixed field widths
  localparam int PICK_W    = 4;   // widest thread index over the supported ring sizes
  localparam int SEM_IDX_W = 3;
  localparam int CNT_W     = 32;
  localparam int PRIO_W    = 8;
  localparam int MAX_SEMS  = 8;   // semaphores reachable through a 3-bit index

  localparam logic [PRIO_W-1:0] NEVER_PRIO = 8'hFF;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 32'sh8000_0000;

  // operation codes on the input channel
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SCHED  = 3'd1,
    OP_SLEEP  = 3'd2,
    OP_WAIT   = 3'd3,
    OP_SIGNAL = 3'd4,
    OP_INIT   = 3'd5
  } op_t;

  // commands broadcast to the thread cells
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_TICK,
    CELL_SLEEP,
    CELL_BLOCK,
    CELL_WAKE,
    CELL_SEED,
    CELL_STEP
  } cell_op_t;

  typedef enum logic {
    SCAN_SCHED,
    SCAN_SIGNAL
  } scan_mode_t;

  typedef enum logic [1:0] {
    SEM_HOLD,
    SEM_DEC,
    SEM_INC,
    SEM_LOAD
  } sem_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    cell_op_t               op;
    logic [PICK_W-1:0]      target;
    scan_mode_t             mode;
    logic [SEM_IDX_W-1:0]   sem;
    logic [CNT_W-1:0]       sleep;
  } cell_cmd_t;

  // partial result carried from cell to cell around the ring
  typedef struct packed {
    logic                found;
    logic [PRIO_W-1:0]   best;
    logic [PICK_W-1:0]   pick;
  } scan_t;

endpackage
`default_nettype wire

[hw/rtl/pts_cell.sv]
`default_nettype none
module pts_cell import pts_pkg::*; #(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [PRIO_W-1:0] prio,
  input  wire cell_cmd_t         cmd,
  input  wire logic              prev_tok,
  input  wire scan_t             prev_scan,
  output logic                   tok,
  output scan_t                  scan
);

  localparam logic [PICK_W-1:0] MY_ID = PICK_W'(INDEX);

  logic [CNT_W-1:0]     sleep_left;
  logic                 blocked;
  logic [SEM_IDX_W-1:0] blocked_sem;

  logic  hit;
  logic  ready;
  scan_t scan_next;

  assign hit   = (cmd.target == MY_ID);
  assign ready = !blocked && (sleep_left == '0);

  // fold this thread into the partial result from the neighbor
  always_comb begin
    scan_next = prev_scan;
    case (cmd.mode)
      SCAN_SCHED: begin
        if (ready && (prio < prev_scan.best)) begin
          scan_next.found = 1'b1;
          scan_next.best  = prio;
          scan_next.pick  = MY_ID;
        end
      end
      SCAN_SIGNAL: begin
        if (!prev_scan.found && blocked && (blocked_sem == cmd.sem)) begin
          scan_next.found = 1'b1;
          scan_next.pick  = MY_ID;
        end
      end
      default: scan_next = prev_scan;
    endcase
  end

  // thread state and scan token
  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_left  <= '0;
      blocked     <= 1'b0;
      blocked_sem <= '0;
      tok         <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_TICK: begin
          if (sleep_left != '0) sleep_left <= sleep_left - 1'b1;
        end
        CELL_SLEEP: begin
          if (hit) sleep_left <= cmd.sleep;
        end
        CELL_BLOCK: begin
          if (hit) begin
            blocked     <= 1'b1;
            blocked_sem <= cmd.sem;
          end
        end
        CELL_WAKE: begin
          if (hit) begin
            blocked     <= 1'b0;
            blocked_sem <= '0;
          end
        end
        CELL_SEED: tok <= hit;
        CELL_STEP: tok <= prev_tok;
        default: ;
      endcase
    end
  end

  // scan payload, seeded at the running thread, passed on behind the token
  always_ff @(posedge clk) begin
    if (cmd.op == CELL_SEED && hit) begin
      scan.found <= 1'b0;
      scan.best  <= NEVER_PRIO;
      scan.pick  <= MY_ID;
    end else if (cmd.op == CELL_STEP && prev_tok) begin
      scan <= scan_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pts_sem.sv]
`default_nettype none
module pts_sem import pts_pkg::*; #(
  parameter int SEM_N = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [SEM_IDX_W-1:0]    idx,
  input  wire sem_op_t                 op,
  input  wire logic signed [CNT_W-1:0] wdata,
  output logic                         ok,
  output logic signed [CNT_W-1:0]      nxt
);

  localparam int SW = (SEM_N > 1) ? $clog2(SEM_N) : 1;

  logic signed [CNT_W-1:0] cnt [SEM_N];
  logic signed [CNT_W-1:0] cur;

  assign ok  = (int'(idx) < SEM_N);
  assign cur = ok ? cnt[idx[SW-1:0]] : '0;

  // count update: saturating decrement or increment, or a load
  always_comb begin
    case (op)
      SEM_DEC:  nxt = (cur == CNT_MIN) ? cur : cur - 1'b1;
      SEM_INC:  nxt = (cur == CNT_MAX) ? cur : cur + 1'b1;
      SEM_LOAD: nxt = wdata;
      default:  nxt = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEM_N; i++) cnt[i] <= '0;
    end else if (ok && op != SEM_HOLD) begin
      cnt[idx[SW-1:0]] <= nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/priority_thread_scheduler.sv]
`default_nettype none
// sequence: an op that needs no ring scan passes through EXEC and then OUT, where its result is
// registered; a schedule, and a signal that leaves its count at or below zero, go through
// EXEC, SCAN, FINISH and OUT: the token walks the ring of cells one thread per cycle, then FINISH
// applies the pick. One operation in flight; the next transfer is taken the cycle after the
// result is loaded, and the load waits in OUT while out_stall holds a pending result
// reset (rst, synchronous): thread 0 runs, no sleep, no thread blocked, counts and priorities 0
module priority_thread_scheduler import pts_pkg::*; #(
  parameter int THREADS    = 8,
  parameter int SEMAPHORES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [63:0]         cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          op,
  input  wire logic [2:0]          sem_index,
  input  wire logic [31:0]         sleep_ms,
  input  wire logic signed [31:0]  init_count,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               running_thread,
  output logic                     must_suspend,
  output logic signed [31:0]       sem_value,
  output logic                     woken_valid,
  output logic [2:0]               woken_thread,
  output logic                     signal_error
);

  localparam int TW    = $clog2(THREADS);
  localparam int SCW   = $clog2(THREADS + 1);
  localparam int SEM_N = (SEMAPHORES < MAX_SEMS) ? SEMAPHORES : MAX_SEMS;

  state_t state, state_next;

  logic [63:0]            prio_cfg;
  logic [TW-1:0]          current, current_next;
  logic [TW+2:0]          cur_wide;
  logic [SCW-1:0]         scan_cnt;
  op_t                    op_r;
  logic [SEM_IDX_W-1:0]   sem_r;
  logic [CNT_W-1:0]       sleep_r;
  logic signed [CNT_W-1:0] init_r;

  logic                    res_suspend, res_suspend_next;
  logic signed [CNT_W-1:0] res_sem, res_sem_next;
  logic                    res_woken_valid, res_woken_valid_next;
  logic [2:0]              res_woken, res_woken_next;
  logic                    res_err, res_err_next;
  logic                    out_load;

  cell_cmd_t               cmd;
  sem_op_t                 sem_op;
  logic                    sem_ok;
  logic signed [CNT_W-1:0] sem_nxt;
  logic                    sem_nonpos;
  logic                    scan_last;
  scan_t                   scan_res;

  logic [THREADS-1:0]      toks;
  scan_t                   scans [THREADS];

  assign cur_wide   = {3'b000, current};
  assign sem_nonpos = sem_nxt[CNT_W-1] || (sem_nxt == '0);
  assign scan_last  = (scan_cnt == SCW'(THREADS - 1));
  assign scan_res   = scans[current];

  // ring of thread cells
  for (genvar i = 0; i < THREADS; i++) begin : g_cell
    localparam int PREV = (i == 0) ? THREADS - 1 : i - 1;
    logic [PRIO_W-1:0] prio;
    if (i < 8) begin : g_prio
      assign prio = prio_cfg[PRIO_W*i +: PRIO_W];
    end else begin : g_never
      assign prio = NEVER_PRIO;
    end
    pts_cell #(
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .prio      (prio),
      .cmd       (cmd),
      .prev_tok  (toks[PREV]),
      .prev_scan (scans[PREV]),
      .tok       (toks[i]),
      .scan      (scans[i])
    );
  end

  // semaphore counts
  pts_sem #(
    .SEM_N (SEM_N)
  ) u_sem (
    .clk   (clk),
    .rst   (rst),
    .idx   (sem_r),
    .op    (sem_op),
    .wdata (init_r),
    .ok    (sem_ok),
    .nxt   (sem_nxt)
  );

  // semaphore update, only while executing
  always_comb begin
    sem_op = SEM_HOLD;
    if (state == ST_EXEC) begin
      case (op_r)
        OP_WAIT:   sem_op = SEM_DEC;
        OP_SIGNAL: sem_op = SEM_INC;
        OP_INIT:   sem_op = SEM_LOAD;
        default:   sem_op = SEM_HOLD;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (op_r)
          OP_SCHED:  state_next = ST_SCAN;
          OP_SIGNAL: state_next = (sem_ok && sem_nonpos) ? ST_SCAN : ST_OUT;
          default:   state_next = ST_OUT;
        endcase
      end
      ST_SCAN:   if (scan_last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_stall             = 1'b1;
    out_load             = 1'b0;
    current_next         = current;
    res_suspend_next     = res_suspend;
    res_sem_next         = res_sem;
    res_woken_valid_next = res_woken_valid;
    res_woken_next       = res_woken;
    res_err_next         = res_err;
    cmd.op               = CELL_IDLE;
    cmd.target           = PICK_W'(current);
    cmd.mode             = (op_r == OP_SIGNAL) ? SCAN_SIGNAL : SCAN_SCHED;
    cmd.sem              = sem_r;
    cmd.sleep            = sleep_r;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: begin
        res_suspend_next     = 1'b0;
        res_sem_next         = sem_ok ? sem_nxt : '0;
        res_woken_valid_next = 1'b0;
        res_woken_next       = '0;
        res_err_next         = 1'b0;
        case (op_r)
          OP_TICK:  cmd.op = CELL_TICK;
          OP_SCHED: cmd.op = CELL_SEED;
          OP_SLEEP: begin
            cmd.op           = CELL_SLEEP;
            res_suspend_next = 1'b1;
          end
          OP_WAIT: begin
            if (sem_ok && sem_nxt[CNT_W-1]) begin
              cmd.op           = CELL_BLOCK;
              res_suspend_next = 1'b1;
            end
          end
          OP_SIGNAL: begin
            if (sem_ok && sem_nonpos) cmd.op = CELL_SEED;
          end
          default: ;
        endcase
      end
      ST_SCAN: cmd.op = CELL_STEP;
      ST_FINISH: begin
        if (op_r == OP_SCHED) begin
          current_next = scan_res.pick[TW-1:0];
        end else if (scan_res.found) begin
          cmd.op               = CELL_WAKE;
          cmd.target           = scan_res.pick;
          res_woken_valid_next = 1'b1;
          res_woken_next       = scan_res.pick[2:0];
        end else begin
          res_err_next = 1'b1;
        end
      end
      ST_OUT: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      current   <= '0;
      prio_cfg  <= '0;
      out_valid <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      state   <= state_next;
      current <= current_next;
      if (cfg_wr_en) prio_cfg <= cfg_wr_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_EXEC) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  // captured operation and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r    <= op_t'(op);
      sem_r   <= sem_index;
      sleep_r <= sleep_ms;
      init_r  <= init_count;
    end
    res_suspend     <= res_suspend_next;
    res_sem         <= res_sem_next;
    res_woken_valid <= res_woken_valid_next;
    res_woken       <= res_woken_next;
    res_err         <= res_err_next;
    if (out_load) begin
      running_thread <= cur_wide[2:0];
      must_suspend   <= res_suspend;
      sem_value      <= res_sem;
      woken_valid    <= res_woken_valid;
      woken_thread   <= res_woken;
      signal_error   <= res_err;
    end
  end

endmodule
`default_nettype wire

[verif/priority_thread_scheduler_tb.sv]
module priority_thread_scheduler_tb;
  import pts_pkg::*;

  localparam int N_THREADS = 8;
  localparam int N_SEMS = 8;
  localparam int DIR_ROWS = 25;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 70;
  localparam int SETTLE_CYCLES = N_THREADS + 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [2:0]  run_thr;
    logic        suspend;
    logic [31:0] count;
    logic        woke;
    logic [2:0]  woke_thr;
    logic        err;
  } sched_result_t;

  typedef struct packed {
    bit            is_cfg;
    logic [63:0]   cfg_val;
    logic [2:0]    op;
    logic [2:0]    sem;
    logic [31:0]   sleep;
    logic [31:0]   init;
    bit            typed;
    sched_result_t res;
  } stim_row_t;

  localparam sched_result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [2:0] sem_index = '0;
  logic [31:0] sleep_ms = '0;
  logic signed [31:0] init_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] running_thread;
  logic must_suspend;
  logic signed [31:0] sem_value;
  logic woken_valid;
  logic [2:0] woken_thread;
  logic signal_error;

  // scheduler state mirrored by the predictor
  logic [63:0] prio_word = '0;
  logic [2:0] cur_thread = '0;
  logic [31:0] sleep_cnt [N_THREADS] = '{default: '0};
  logic blocked [N_THREADS] = '{default: 1'b0};
  logic [2:0] blocked_on [N_THREADS] = '{default: '0};
  logic signed [31:0] sem_cnt [N_SEMS] = '{default: '0};

  sched_result_t expected_q [$];
  stim_row_t dir_table [DIR_ROWS];
  pace_t pace = PACE_FULL;
  int failures = 0;
  int quiet_cycles = 0;

  priority_thread_scheduler #(
    .THREADS(N_THREADS),
    .SEMAPHORES(N_SEMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .sem_index(sem_index),
    .sleep_ms(sleep_ms),
    .init_count(init_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .running_thread(running_thread),
    .must_suspend(must_suspend),
    .sem_value(sem_value),
    .woken_valid(woken_valid),
    .woken_thread(woken_thread),
    .signal_error(signal_error)
  );

  always #5 clk = ~clk;

  // advance the scheduler state by one operation and return its result
  function automatic sched_result_t predict_step(input logic [2:0] o, input logic [2:0] s,
                                                 input logic [31:0] sl, input logic [31:0] ic);
    sched_result_t r;
    int t;
    int best;
    int pick;
    bit sem_ok;
    r = '0;
    sem_ok = (int'(s) < N_SEMS);
    case (o)
      OP_TICK: begin
        for (int i = 0; i < N_THREADS; i++)
          if (sleep_cnt[i] != 0) sleep_cnt[i] = sleep_cnt[i] - 1;
      end
      OP_SCHED: begin
        best = int'(NEVER_PRIO);
        pick = int'(cur_thread);
        t = int'(cur_thread);
        for (int i = 0; i < N_THREADS; i++) begin
          t = (t + 1) % N_THREADS;
          if (int'(prio_word[8*t +: 8]) < best && !blocked[t] && sleep_cnt[t] == 0) begin
            best = int'(prio_word[8*t +: 8]);
            pick = t;
          end
        end
        cur_thread = 3'(pick);
      end
      OP_SLEEP: begin
        sleep_cnt[cur_thread] = sl;
        r.suspend = 1'b1;
      end
      OP_WAIT: begin
        if (sem_ok) begin
          if (sem_cnt[s] != CNT_MIN) sem_cnt[s] = sem_cnt[s] - 1;
          if (sem_cnt[s] < 0) begin
            blocked[cur_thread] = 1'b1;
            blocked_on[cur_thread] = s;
            r.suspend = 1'b1;
          end
        end
      end
      OP_SIGNAL: begin
        if (sem_ok) begin
          if (sem_cnt[s] != CNT_MAX) sem_cnt[s] = sem_cnt[s] + 1;
          if (sem_cnt[s] <= 0) begin
            // first waiter on this semaphore after the running thread
            t = int'(cur_thread);
            for (int i = 0; i < N_THREADS; i++) begin
              t = (t + 1) % N_THREADS;
              if (blocked[t] && blocked_on[t] == s) begin
                blocked[t] = 1'b0;
                blocked_on[t] = '0;
                r.woke = 1'b1;
                r.woke_thr = 3'(t);
                break;
              end
            end
            r.err = !r.woke;
          end
        end
      end
      OP_INIT: begin
        if (sem_ok) sem_cnt[s] = ic;
      end
      default: begin
      end
    endcase
    r.run_thr = cur_thread;
    r.count = sem_ok ? sem_cnt[s] : '0;
    return r;
  endfunction

  function automatic int send_gap();
    int pct;
    int g;
    pct = (pace == PACE_SEND_IDLE) ? 87 : (pace == PACE_BOTH) ? 25 : 0;
    g = 0;
    while ($urandom_range(99) < pct) g++;
    return g;
  endfunction

  // offer one input item and record its expected result on transfer
  task automatic send_item(input logic [2:0] o, input logic [2:0] s, input logic [31:0] sl,
                           input logic [31:0] ic, input bit typed, input sched_result_t fixed);
    int gap;
    sched_result_t want;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    sem_index <= s;
    sleep_ms <= sl;
    init_count <= ic;
    do @(posedge clk); while (in_stall);
    want = predict_step(o, s, sl, ic);
    expected_q.push_back(typed ? fixed : want);
  endtask

  // hold off input until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_priorities(input logic [63:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    prio_word = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    end
  endtask

  // result side: check each transfer, then choose the next stall
  always @(posedge clk) begin : result_check
    sched_result_t want;
    int pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual thread %0d value %0h",
                   $time, running_thread, sem_value);
          failures++;
        end else begin
          want = expected_q.pop_front();
          compare_field("running_thread", 32'(want.run_thr), 32'(running_thread));
          compare_field("must_suspend", 32'(want.suspend), 32'(must_suspend));
          compare_field("sem_value", want.count, sem_value);
          compare_field("woken_valid", 32'(want.woke), 32'(woken_valid));
          compare_field("woken_thread", 32'(want.woke_thr), 32'(woken_thread));
          compare_field("signal_error", 32'(want.err), 32'(signal_error));
        end
      end
      pct = (pace == PACE_RECV_STALL) ? 87 : (pace == PACE_BOTH) ? 25 : 0;
      out_stall <= ($urandom_range(99) < pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] cfg_plan [PHASES];
    logic [2:0] o;
    logic [2:0] s;
    logic [31:0] sl;
    logic [31:0] ic;
    int r;

    // directed table: typed results only where they are plain
    dir_table[0]  = '{0, '0, OP_TICK,   3'd0, '0, '0, 1,
                      '{3'd0, 1'b0, 32'h0000_0000, 1'b0, 3'd0, 1'b0}};
    dir_table[1]  = '{0, '0, OP_INIT,   3'd1, '0, 32'h7FFF_FFFF, 1,
                      '{3'd0, 1'b0, 32'h7FFF_FFFF, 1'b0, 3'd0, 1'b0}};
    dir_table[2]  = '{0, '0, OP_SIGNAL, 3'd1, '0, '0, 1,
                      '{3'd0, 1'b0, 32'h7FFF_FFFF, 1'b0, 3'd0, 1'b0}};
    dir_table[3]  = '{0, '0, OP_INIT,   3'd2, '0, 32'h8000_0000, 1,
                      '{3'd0, 1'b0, 32'h8000_0000, 1'b0, 3'd0, 1'b0}};
    dir_table[4]  = '{0, '0, OP_WAIT,   3'd2, '0, '0, 1,
                      '{3'd0, 1'b1, 32'h8000_0000, 1'b0, 3'd0, 1'b0}};
    dir_table[5]  = '{0, '0, OP_SCHED,  3'd2, '0, '0, 0, NO_RES};
    dir_table[6]  = '{0, '0, OP_INIT,   3'd3, '0, 32'hFFFF_FFFF, 0, NO_RES};
    dir_table[7]  = '{0, '0, OP_SIGNAL, 3'd3, '0, '0, 1,
                      '{3'd1, 1'b0, 32'h0000_0000, 1'b0, 3'd0, 1'b1}};
    dir_table[8]  = '{0, '0, OP_SIGNAL, 3'd2, '0, '0, 0, NO_RES};
    dir_table[9]  = '{0, '0, OP_SLEEP,  3'd0, 32'hFFFF_FFFF, '0, 0, NO_RES};
    dir_table[10] = '{0, '0, OP_SCHED,  3'd0, '0, '0, 0, NO_RES};
    dir_table[11] = '{0, '0, OP_SLEEP,  3'd5, 32'h0000_0000, '0, 0, NO_RES};
    dir_table[12] = '{0, '0, OP_SPARE_A, 3'd5, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, NO_RES};
    dir_table[13] = '{0, '0, OP_SPARE_B, 3'd7, '0, 32'h8000_0000, 0, NO_RES};
    dir_table[14] = '{0, '0, OP_TICK,   3'd6, '0, '0, 0, NO_RES};
    dir_table[15] = '{1, 64'hFFFF_FFFF_FFFF_FFFF, OP_TICK, '0, '0, '0, 0, NO_RES};
    dir_table[16] = '{0, '0, OP_SCHED,  3'd0, '0, '0, 0, NO_RES};
    dir_table[17] = '{1, 64'h0001_0203_0405_0607, OP_TICK, '0, '0, '0, 0, NO_RES};
    dir_table[18] = '{0, '0, OP_SCHED,  3'd1, '0, '0, 0, NO_RES};
    dir_table[19] = '{1, 64'h10FF_1010_FF20_1010, OP_TICK, '0, '0, '0, 0, NO_RES};
    dir_table[20] = '{0, '0, OP_SCHED,  3'd4, '0, '0, 0, NO_RES};
    dir_table[21] = '{0, '0, OP_WAIT,   3'd4, '0, '0, 0, NO_RES};
    dir_table[22] = '{0, '0, OP_SCHED,  3'd4, '0, '0, 0, NO_RES};
    dir_table[23] = '{0, '0, OP_SIGNAL, 3'd4, '0, '0, 0, NO_RES};
    dir_table[24] = '{0, '0, OP_SCHED,  3'd4, '0, '0, 0, NO_RES};

    // priority settings, one per random phase
    cfg_plan[0] = 64'h0000_0000_0000_0000;
    cfg_plan[1] = 64'h0001_0203_0405_0607;
    cfg_plan[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    cfg_plan[3] = {$urandom, $urandom};
    cfg_plan[4] = 64'h10FF_1010_FF20_1010;
    cfg_plan[5] = 64'hFEFF_FEFF_FEFF_FEFF;
    cfg_plan[6] = {$urandom, $urandom} | 64'hFF00_0000_00FF_0000;
    cfg_plan[7] = 64'h0000_0000_0000_0000;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].is_cfg) write_priorities(dir_table[i].cfg_val);
      else send_item(dir_table[i].op, dir_table[i].sem, dir_table[i].sleep,
                     dir_table[i].init, dir_table[i].typed, dir_table[i].res);
    end

    // random phases: mostly small semaphores and short sleeps to keep threads cycling
    for (int ph = 0; ph < PHASES; ph++) begin
      write_priorities(cfg_plan[ph]);
      pace = pace_t'(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(99);
        if (r < 18) o = OP_TICK;
        else if (r < 42) o = OP_SCHED;
        else if (r < 52) o = OP_SLEEP;
        else if (r < 67) o = OP_WAIT;
        else if (r < 84) o = OP_SIGNAL;
        else if (r < 95) o = OP_INIT;
        else o = ($urandom_range(1) == 1) ? OP_SPARE_A : OP_SPARE_B;
        s = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
        sl = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(6));
        ic = ($urandom_range(9) == 0) ? $urandom : 32'(int'($urandom_range(6)) - 3);
        send_item(o, s, sl, ic, 0, NO_RES);
      end
    end

    drain();
    if (failures == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[priority_thread_scheduler.f]
hw/rtl/pts_pkg.sv
hw/rtl/pts_cell.sv
hw/rtl/pts_sem.sv
hw/rtl/priority_thread_scheduler.sv
verif/priority_thread_scheduler_tb.sv
